### hdl/svic_pkg.sv
// shared types, codes and constants for the sprite vm instruction core
// no dependencies; imported by every module of the core but svic_ram
package svic_pkg;

    localparam int MEM_BYTES     = 4096;
    localparam int STACK_DEPTH   = 16;
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int REG_COUNT     = 16;
    localparam logic [11:0] START_ADDRESS_DEFAULT = 12'h200;

    localparam int MEM_AW = $clog2(MEM_BYTES);
    localparam int STK_AW = $clog2(STACK_DEPTH);
    localparam int ROW_AW = $clog2(SCREEN_HEIGHT);
    localparam int REG_AW = $clog2(REG_COUNT);

    // item actions
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_STEP = 2'd1;
    localparam logic [1:0] ACT_ROW  = 2'd2;
    localparam logic [1:0] ACT_READ = 2'd3;

    // result status codes
    localparam logic [1:0] ST_DONE        = 2'd0;
    localparam logic [1:0] ST_HALTED      = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

    // register map
    localparam logic [1:0] ADDR_RUN_ENABLE = 2'd0;

    // opcode classes and sub-codes used by controller and datapath
    localparam logic [3:0] OPC_ALU  = 4'h8;
    localparam logic [3:0] OPC_DRAW = 4'hD;
    localparam logic [3:0] OPC_MISC = 4'hF;
    localparam logic [7:0] NN_BCD   = 8'h33;
    localparam logic [7:0] NN_STORE = 8'h55;
    localparam logic [7:0] NN_LOAD  = 8'h65;

    typedef struct packed {
        logic [1:0]  action;
        logic [11:0] address;
        logic [7:0]  data;
        logic [15:0] keys;
    } svic_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] program_counter;
        logic [15:0] index_value;
        logic [7:0]  delay_value;
        logic [7:0]  sound_value;
        logic [7:0]  read_byte;
        logic [63:0] display_row;
    } svic_result_t;

    // datapath micro-operations
    typedef enum logic [4:0] {
        UOP_NONE,
        UOP_CLEAR,
        UOP_LATCH,
        UOP_MEM_LOAD,
        UOP_MEM_READ,
        UOP_CAP_BYTE,
        UOP_FETCH_HI,
        UOP_FETCH_LO,
        UOP_CAP_LO,
        UOP_RD_VY,
        UOP_CAP_VY,
        UOP_EXEC,
        UOP_WR_VF,
        UOP_RET,
        UOP_COMMIT,
        UOP_BCD,
        UOP_ST_RD,
        UOP_ST_WR,
        UOP_LD_RD,
        UOP_LD_WR,
        UOP_DRAW_RD,
        UOP_DRAW_WR,
        UOP_RESULT
    } svic_uop_t;

    typedef struct packed {
        svic_uop_t          uop;
        logic [REG_AW-1:0]  k;
        logic [MEM_AW-1:0]  clr_addr;
        logic [1:0]         status;
    } svic_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] opc;
        logic [3:0] x;
        logic [3:0] n;
        logic [7:0] nn;
        logic       unsupported;
        logic       ret;
        logic       flag_op;
    } svic_stat_t;

endpackage

### hdl/svic_ram.sv
// generic single port ram with registered read
// depends on nothing
module svic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[addr] <= wdata;
        end
        rd_reg <= mem_array[addr];
    end

    assign rdata = rd_reg;

endmodule

### hdl/svic_dp.sv
// datapath: memories, architectural registers, frame buffer and result register
// depends on svic_pkg and svic_ram
module svic_dp
    import svic_pkg::*;
#(
    parameter logic [11:0] START_ADDRESS = START_ADDRESS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  svic_cmd_t    cmd,
    input  svic_item_t   in_item,
    output svic_stat_t   stat,
    output svic_result_t result
);

    localparam logic [7:0] NN_SKP = 8'h9E;
    localparam logic [7:0] NN_SKNP = 8'hA1;
    localparam logic [7:0] NN_GET_DT = 8'h07;
    localparam logic [7:0] NN_SET_DT = 8'h15;
    localparam logic [7:0] NN_ADD_I = 8'h1E;
    localparam logic [7:0] NN_FONT = 8'h29;
    localparam logic [7:0] NN_CLS = 8'hE0;
    localparam logic [7:0] NN_RET = 8'hEE;

    svic_item_t           item_reg;
    logic [7:0]           hi_reg, lo_reg, vx_reg, vy_reg, rb_reg;
    logic [MEM_AW-1:0]    pc_reg, pc_next_reg;
    logic [15:0]          index_reg;
    logic [7:0]           delay_reg, sound_reg;
    logic [STK_AW-1:0]    sp_reg;
    logic                 flag_reg;
    logic [63:0]          frame_reg [SCREEN_HEIGHT];
    svic_result_t         result_reg;

    logic [MEM_AW-1:0]    mem_addr;
    logic                 mem_we;
    logic [7:0]           mem_wdata, mem_rdata;
    logic [REG_AW-1:0]    v_addr;
    logic                 v_we;
    logic [7:0]           v_wdata, v_rdata;
    logic [STK_AW-1:0]    stk_addr;
    logic                 stk_we;
    logic [MEM_AW-1:0]    stk_wdata, stk_rdata;

    logic [3:0]           opc, x, y, n;
    logic [7:0]           nn;
    logic [MEM_AW-1:0]    nnn, pc2, pc4, idx_k, pc_calc;
    logic [7:0]           alu_res, delay_dec, sound_dec, exec_res;
    logic                 alu_flag, alu_valid, exec_we, key_hit;
    logic [8:0]           sum9;
    logic [1:0]           hund;
    logic [6:0]           rem100;
    logic [14:0]          tens_prod;
    logic [3:0]           tens, ones;
    logic [7:0]           digit;
    logic [ROW_AW-1:0]    draw_row;
    logic [63:0]          sprite, mask;
    logic [5:0]           xs;

    assign opc = hi_reg[7:4];
    assign x   = hi_reg[3:0];
    assign y   = lo_reg[7:4];
    assign n   = lo_reg[3:0];
    assign nn  = lo_reg;
    assign nnn = {x, lo_reg};
    assign pc2 = pc_reg + MEM_AW'(2);
    assign pc4 = pc_reg + MEM_AW'(4);
    assign idx_k = index_reg[MEM_AW-1:0] + MEM_AW'(cmd.k);

    assign stat.action  = item_reg.action;
    assign stat.opc     = opc;
    assign stat.x       = x;
    assign stat.n       = n;
    assign stat.nn      = nn;
    assign stat.ret     = (hi_reg == 8'h00) && (lo_reg == NN_RET);
    assign stat.flag_op = (n == 4'h4) || (n == 4'h5) || (n == 4'h6) || (n == 4'h7) ||
                          (n == 4'hE);
    always_comb
    begin
        case (opc)
            4'h0: stat.unsupported = !((x == 4'h0) && ((nn == NN_CLS) || (nn == NN_RET)));
            4'hB, 4'hC: stat.unsupported = 1'b1;
            OPC_MISC: stat.unsupported = (nn == 8'h0A) || (nn == 8'h18);
            default: stat.unsupported = 1'b0;
        endcase
    end

    // 8xy arithmetic
    assign sum9 = {1'b0, vx_reg} + {1'b0, vy_reg};
    always_comb
    begin
        alu_res   = vx_reg;
        alu_flag  = 1'b0;
        alu_valid = 1'b1;
        case (n)
            4'h0: alu_res = vy_reg;
            4'h1: alu_res = vx_reg | vy_reg;
            4'h2: alu_res = vx_reg & vy_reg;
            4'h3: alu_res = vx_reg ^ vy_reg;
            4'h4:
            begin
                alu_res  = sum9[7:0];
                alu_flag = sum9[8];
            end
            4'h5:
            begin
                alu_res  = vx_reg - vy_reg;
                alu_flag = vx_reg >= vy_reg;
            end
            4'h6:
            begin
                alu_res  = {1'b0, vx_reg[7:1]};
                alu_flag = vx_reg[0];
            end
            4'h7:
            begin
                alu_res  = vy_reg - vx_reg;
                alu_flag = vy_reg >= vx_reg;
            end
            4'hE:
            begin
                alu_res  = {vx_reg[6:0], 1'b0};
                alu_flag = vx_reg[7];
            end
            default: alu_valid = 1'b0;
        endcase
    end

    assign delay_dec = (delay_reg != 8'd0) ? delay_reg - 8'd1 : 8'd0;
    assign sound_dec = (sound_reg != 8'd0) ? sound_reg - 8'd1 : 8'd0;
    assign key_hit   = item_reg.keys[vx_reg[3:0]];

    // register writeback and next pc in the execute cycle
    always_comb
    begin
        exec_we  = 1'b0;
        exec_res = alu_res;
        pc_calc  = pc2;
        case (opc)
            4'h1, 4'h2: pc_calc = nnn;
            4'h3: pc_calc = (vx_reg == nn) ? pc4 : pc2;
            4'h4: pc_calc = (vx_reg != nn) ? pc4 : pc2;
            4'h5: pc_calc = (vx_reg == vy_reg) ? pc4 : pc2;
            4'h9: pc_calc = (vx_reg != vy_reg) ? pc4 : pc2;
            4'h6:
            begin
                exec_we  = 1'b1;
                exec_res = nn;
            end
            4'h7:
            begin
                exec_we  = 1'b1;
                exec_res = vx_reg + nn;
            end
            OPC_ALU: exec_we = alu_valid;
            4'hE:
            begin
                if (((nn == NN_SKP) && key_hit) || ((nn == NN_SKNP) && !key_hit))
                begin
                    pc_calc = pc4;
                end
            end
            OPC_MISC:
            begin
                if (nn == NN_GET_DT)
                begin
                    exec_we  = 1'b1;
                    exec_res = delay_dec;
                end
            end
            default: exec_we = 1'b0;
        endcase
    end

    // bcd digits: compare and subtract for hundreds, reciprocal multiply for tens
    assign hund      = (vx_reg >= 8'd200) ? 2'd2 : ((vx_reg >= 8'd100) ? 2'd1 : 2'd0);
    assign rem100    = 7'(vx_reg - 8'(hund) * 8'd100);
    assign tens_prod = 15'(rem100) * 15'd205;
    assign tens      = tens_prod[14:11];
    assign ones      = 4'(rem100 - 7'(tens) * 7'd10);
    always_comb
    begin
        case (cmd.k[1:0])
            2'd0: digit = {6'd0, hund};
            2'd1: digit = {4'd0, tens};
            default: digit = {4'd0, ones};
        endcase
    end

    // sprite row rotated to the x position
    assign xs       = vx_reg[5:0];
    assign sprite   = {mem_rdata, 56'd0};
    assign mask     = (sprite >> xs) | (sprite << (6'd0 - xs));
    assign draw_row = vy_reg[ROW_AW-1:0] + ROW_AW'(cmd.k);

    // memory port steering
    always_comb
    begin
        mem_addr  = pc_reg;
        mem_we    = 1'b0;
        mem_wdata = v_rdata;
        v_addr    = x;
        v_we      = 1'b0;
        v_wdata   = exec_res;
        stk_addr  = sp_reg;
        stk_we    = 1'b0;
        stk_wdata = pc2;
        case (cmd.uop)
            UOP_CLEAR:
            begin
                mem_addr  = cmd.clr_addr;
                mem_we    = 1'b1;
                mem_wdata = 8'd0;
                v_addr    = cmd.clr_addr[REG_AW-1:0];
                v_we      = 1'b1;
                v_wdata   = 8'd0;
                stk_addr  = cmd.clr_addr[STK_AW-1:0];
                stk_we    = 1'b1;
                stk_wdata = '0;
            end
            UOP_MEM_LOAD:
            begin
                mem_addr  = item_reg.address;
                mem_we    = 1'b1;
                mem_wdata = item_reg.data;
            end
            UOP_MEM_READ: mem_addr = item_reg.address;
            UOP_FETCH_LO: mem_addr = pc_reg + MEM_AW'(1);
            UOP_RD_VY:    v_addr = y;
            UOP_EXEC:
            begin
                v_we = exec_we;
                if (opc == 4'h0)
                begin
                    stk_addr = sp_reg - STK_AW'(1);
                end
                stk_we = (opc == 4'h2);
            end
            UOP_WR_VF:
            begin
                v_addr  = REG_AW'(REG_COUNT - 1);
                v_we    = 1'b1;
                v_wdata = {7'd0, flag_reg};
            end
            UOP_BCD:
            begin
                mem_addr  = idx_k;
                mem_we    = 1'b1;
                mem_wdata = digit;
            end
            UOP_ST_RD: v_addr = cmd.k;
            UOP_ST_WR:
            begin
                mem_addr = idx_k;
                mem_we   = 1'b1;
            end
            UOP_LD_RD, UOP_DRAW_RD: mem_addr = idx_k;
            UOP_LD_WR:
            begin
                v_addr  = cmd.k;
                v_we    = 1'b1;
                v_wdata = mem_rdata;
            end
            default: mem_we = 1'b0;
        endcase
    end

    svic_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    svic_ram #(.WIDTH(8), .DEPTH(REG_COUNT)) u_vreg (
        .clk   (clk),
        .we    (v_we),
        .addr  (v_addr),
        .wdata (v_wdata),
        .rdata (v_rdata)
    );

    svic_ram #(.WIDTH(MEM_AW), .DEPTH(STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .addr  (stk_addr),
        .wdata (stk_wdata),
        .rdata (stk_rdata)
    );

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.uop)
            UOP_LATCH:    item_reg <= in_item;
            UOP_CAP_BYTE: rb_reg <= mem_rdata;
            UOP_FETCH_LO: hi_reg <= mem_rdata;
            UOP_CAP_LO:   lo_reg <= mem_rdata;
            UOP_RD_VY:    vx_reg <= v_rdata;
            UOP_CAP_VY:   vy_reg <= v_rdata;
            UOP_EXEC:     pc_next_reg <= pc_calc;
            UOP_RET:      pc_next_reg <= stk_rdata;
            UOP_RESULT:
            begin
                result_reg.status          <= cmd.status;
                result_reg.program_counter <= pc_reg;
                result_reg.index_value     <= index_reg;
                result_reg.delay_value     <= delay_reg;
                result_reg.sound_value     <= sound_reg;
                result_reg.read_byte       <= (item_reg.action == ACT_READ) ? rb_reg : 8'd0;
                result_reg.display_row     <= (item_reg.action == ACT_ROW) ?
                                              frame_reg[item_reg.address[ROW_AW-1:0]] : 64'd0;
            end
            default: rb_reg <= rb_reg;
        endcase
    end

    // architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= START_ADDRESS;
            index_reg <= 16'd0;
            delay_reg <= 8'd0;
            sound_reg <= 8'd0;
            sp_reg    <= '0;
            flag_reg  <= 1'b0;
            for (int r = 0; r < SCREEN_HEIGHT; r++)
            begin
                frame_reg[r] <= 64'd0;
            end
        end
        else
        begin
            case (cmd.uop)
                UOP_EXEC:
                begin
                    // fx15 loads the delay timer instead of the decrement
                    delay_reg <= ((opc == OPC_MISC) && (nn == NN_SET_DT)) ? vx_reg : delay_dec;
                    sound_reg <= sound_dec;
                    // a draw starts with no collision seen
                    flag_reg  <= (opc == OPC_DRAW) ? 1'b0 : alu_flag;
                    case (opc)
                        4'h0:
                        begin
                            if (nn == NN_CLS)
                            begin
                                for (int r = 0; r < SCREEN_HEIGHT; r++)
                                begin
                                    frame_reg[r] <= 64'd0;
                                end
                            end
                            else
                            begin
                                sp_reg <= sp_reg - STK_AW'(1);
                            end
                        end
                        4'h2: sp_reg <= sp_reg + STK_AW'(1);
                        4'hA: index_reg <= {4'd0, nnn};
                        OPC_MISC:
                        begin
                            case (nn)
                                NN_ADD_I:  index_reg <= index_reg + {8'd0, vx_reg};
                                NN_FONT:   index_reg <= {6'd0, vx_reg, 2'd0} + {8'd0, vx_reg};
                                default:   index_reg <= index_reg;
                            endcase
                        end
                        default: sp_reg <= sp_reg;
                    endcase
                end
                UOP_DRAW_WR:
                begin
                    frame_reg[draw_row] <= frame_reg[draw_row] ^ mask;
                    if ((frame_reg[draw_row] & mask) != 64'd0)
                    begin
                        flag_reg <= 1'b1;
                    end
                end
                UOP_COMMIT: pc_reg <= pc_next_reg;
                default: pc_reg <= pc_reg;
            endcase
        end
    end

    assign result = result_reg;

endmodule

### hdl/svic_ctrl.sv
// controller state machine: clearing pass, item dispatch, instruction sequencing
// depends on svic_pkg
module svic_ctrl
    import svic_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       run_enable,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  svic_stat_t stat,
    output svic_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_CAP_BYTE,
        S_FETCH_LO,
        S_CAP_LO,
        S_RD_VY,
        S_CAP_VY,
        S_EXEC,
        S_RET,
        S_WR_VF,
        S_BCD,
        S_ST_RD,
        S_ST_WR,
        S_LD_RD,
        S_LD_WR,
        S_DRAW_RD,
        S_DRAW_WR,
        S_COMMIT,
        S_FINISH
    } state_t;

    state_t            state_reg;
    logic [MEM_AW-1:0] clr_reg;
    logic [REG_AW-1:0] k_reg;
    logic [1:0]        status_reg;
    logic              out_valid_reg;
    logic              accept, slot_free;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign slot_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.k        = k_reg;
        cmd.clr_addr = clr_reg;
        cmd.status   = status_reg;
        unique case (state_reg)
            S_CLEAR:    cmd.uop = UOP_CLEAR;
            S_IDLE:     cmd.uop = accept ? UOP_LATCH : UOP_NONE;
            S_DISPATCH:
            begin
                unique case (stat.action)
                    ACT_LOAD: cmd.uop = UOP_MEM_LOAD;
                    ACT_READ: cmd.uop = UOP_MEM_READ;
                    ACT_STEP: cmd.uop = run_enable ? UOP_FETCH_HI : UOP_NONE;
                    default:  cmd.uop = UOP_NONE;
                endcase
            end
            S_CAP_BYTE: cmd.uop = UOP_CAP_BYTE;
            S_FETCH_LO: cmd.uop = UOP_FETCH_LO;
            S_CAP_LO:   cmd.uop = UOP_CAP_LO;
            S_RD_VY:    cmd.uop = UOP_RD_VY;
            S_CAP_VY:   cmd.uop = UOP_CAP_VY;
            S_EXEC:     cmd.uop = UOP_EXEC;
            S_RET:      cmd.uop = UOP_RET;
            S_WR_VF:    cmd.uop = UOP_WR_VF;
            S_BCD:      cmd.uop = UOP_BCD;
            S_ST_RD:    cmd.uop = UOP_ST_RD;
            S_ST_WR:    cmd.uop = UOP_ST_WR;
            S_LD_RD:    cmd.uop = UOP_LD_RD;
            S_LD_WR:    cmd.uop = UOP_LD_WR;
            S_DRAW_RD:  cmd.uop = UOP_DRAW_RD;
            S_DRAW_WR:  cmd.uop = UOP_DRAW_WR;
            S_COMMIT:   cmd.uop = UOP_COMMIT;
            S_FINISH:   cmd.uop = slot_free ? UOP_RESULT : UOP_NONE;
            default:    cmd.uop = UOP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            k_reg         <= '0;
            status_reg    <= ST_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new result goes out when the slot frees, else a taken one drops
            if ((state_reg == S_FINISH) && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + MEM_AW'(1);
                    if (clr_reg == MEM_AW'(MEM_BYTES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    status_reg <= ST_DONE;
                    if (accept)
                    begin
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    unique case (stat.action)
                        ACT_READ: state_reg <= S_CAP_BYTE;
                        ACT_STEP:
                        begin
                            if (run_enable)
                            begin
                                state_reg <= S_FETCH_LO;
                            end
                            else
                            begin
                                status_reg <= ST_HALTED;
                                state_reg  <= S_FINISH;
                            end
                        end
                        default: state_reg <= S_FINISH;
                    endcase
                end
                S_CAP_BYTE: state_reg <= S_FINISH;
                S_FETCH_LO: state_reg <= S_CAP_LO;
                S_CAP_LO:   state_reg <= S_RD_VY;
                S_RD_VY:    state_reg <= S_CAP_VY;
                S_CAP_VY:
                begin
                    if (stat.unsupported)
                    begin
                        status_reg <= ST_UNSUPPORTED;
                        state_reg  <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    k_reg <= '0;
                    if (stat.ret)
                    begin
                        state_reg <= S_RET;
                    end
                    else if ((stat.opc == OPC_ALU) && stat.flag_op)
                    begin
                        state_reg <= S_WR_VF;
                    end
                    else if (stat.opc == OPC_DRAW)
                    begin
                        state_reg <= (stat.n == 4'd0) ? S_WR_VF : S_DRAW_RD;
                    end
                    else if ((stat.opc == OPC_MISC) && (stat.nn == NN_BCD))
                    begin
                        state_reg <= S_BCD;
                    end
                    else if ((stat.opc == OPC_MISC) && (stat.nn == NN_STORE))
                    begin
                        state_reg <= S_ST_RD;
                    end
                    else if ((stat.opc == OPC_MISC) && (stat.nn == NN_LOAD))
                    begin
                        state_reg <= S_LD_RD;
                    end
                    else
                    begin
                        state_reg <= S_COMMIT;
                    end
                end
                S_RET:   state_reg <= S_COMMIT;
                S_WR_VF: state_reg <= S_COMMIT;
                S_BCD:
                begin
                    k_reg <= k_reg + REG_AW'(1);
                    if (k_reg == REG_AW'(2))
                    begin
                        state_reg <= S_COMMIT;
                    end
                end
                S_ST_RD: state_reg <= S_ST_WR;
                S_ST_WR:
                begin
                    k_reg     <= k_reg + REG_AW'(1);
                    state_reg <= (k_reg == stat.x) ? S_COMMIT : S_ST_RD;
                end
                S_LD_RD: state_reg <= S_LD_WR;
                S_LD_WR:
                begin
                    k_reg     <= k_reg + REG_AW'(1);
                    state_reg <= (k_reg == stat.x) ? S_COMMIT : S_LD_RD;
                end
                S_DRAW_RD: state_reg <= S_DRAW_WR;
                S_DRAW_WR:
                begin
                    k_reg     <= k_reg + REG_AW'(1);
                    state_reg <= (k_reg == stat.n - 4'd1) ? S_WR_VF : S_DRAW_RD;
                end
                S_COMMIT: state_reg <= S_FINISH;
                S_FINISH:
                begin
                    if (slot_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_DISPATCH))
        else $error("accepted request did not start dispatch");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> in_stall)
        else $error("request taken during clearing pass");

    a_finish_waits: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FINISH) && out_valid_reg && out_stall) |=>
        ((state_reg == S_FINISH) && out_valid_reg))
        else $error("result overwrote an untaken result");

    a_bcd_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BCD) |-> (k_reg <= REG_AW'(2)))
        else $error("bcd digit index out of range");

endmodule

### hdl/sprite_vm_instruction_core.sv
// sprite vm instruction core: one request in, one result out, a request at a time
// each instruction runs as a sequence of controller states; the single memory port and
// the single register file port set that sequence
// after reset a clearing pass zeroes memory, registers and stack, no request
// is taken meanwhile (configuration writes are); pc resets to START_ADDRESS, timers to zero
module sprite_vm_instruction_core
    import svic_pkg::*;
#(
    parameter logic [11:0] START_ADDRESS = START_ADDRESS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    // apb style configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // request channel
    input  logic         in_valid,
    output logic         in_stall,
    input  svic_item_t   in_item,
    // result channel
    output logic         out_valid,
    input  logic         out_stall,
    output svic_result_t out_result
);

    logic       run_enable_reg;
    svic_cmd_t  cmd;
    svic_stat_t stat;

    // single register; reads of other addresses return zero
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_RUN_ENABLE) ? {31'd0, run_enable_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_enable_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_RUN_ENABLE))
        begin
            run_enable_reg <= pwdata[0];
        end
    end

    // sequencer issues one micro-operation per cycle to the datapath
    svic_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .run_enable (run_enable_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    // memories, registers, frame buffer and the result register
    svic_dp #(.START_ADDRESS(START_ADDRESS)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .in_item (in_item),
        .stat    (stat),
        .result  (out_result)
    );

endmodule

### test/tb_sprite_vm_instruction_core.sv
// testbench for the sprite vm instruction core: directed table, demo program, then random programs,
// every result checked against an in-bench interpreter model
// depends on svic_pkg and sprite_vm_instruction_core
module tb_sprite_vm_instruction_core;
    timeunit 1ns;
    timeprecision 1ps;
    import svic_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [1:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         in_valid = 1'b0;
    logic         in_stall;
    svic_item_t   in_item = '0;
    logic         out_valid;
    logic         out_stall = 1'b0;
    svic_result_t out_result;

    always #1 clk = ~clk;

    sprite_vm_instruction_core DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_result(out_result)
    );

    // interpreter state mirrored in the bench
    logic [7:0]  mem_m [MEM_BYTES];
    logic [7:0]  vreg_m [16];
    logic [11:0] stack_m [STACK_DEPTH];
    logic [3:0]  sp_m;
    logic [11:0] pc_m;
    logic [15:0] idx_m;
    logic [7:0]  dt_m;
    logic [7:0]  st_m;
    logic [63:0] frame_m [SCREEN_HEIGHT];
    logic        run_m;

    svic_result_t pending_results[$];
    int errors = 0;
    int idle_send_pct = 0;
    int idle_recv_pct = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    // runs one instruction in the model, returns the status
    function automatic logic [1:0] interpret_step(input logic [15:0] keys);
        logic [15:0] op;
        logic [3:0]  x, y, n;
        logic [7:0]  nn, a, b, f, bits;
        logic [11:0] nxt;
        logic [8:0]  sum;
        logic [63:0] m;
        logic        hit;
        int          yy, xx;
        op = {mem_m[pc_m], mem_m[pc_m + 12'd1]};
        x = op[11:8]; y = op[7:4]; n = op[3:0]; nn = op[7:0];
        // unsupported opcodes leave everything alone, timers included
        if ((op[15:12] == 4'h0 && op[11:0] != 12'h0E0 && op[11:0] != 12'h0EE)
            || op[15:12] == 4'hB || op[15:12] == 4'hC
            || (op[15:12] == 4'hF && (nn == 8'h0A || nn == 8'h18)))
            return ST_UNSUPPORTED;
        if (dt_m != 0) dt_m--;
        if (st_m != 0) st_m--;
        nxt = pc_m + 12'd2;
        a = vreg_m[x]; b = vreg_m[y];
        case (op[15:12])
            4'h0:
            begin
                if (op[11:0] == 12'h0E0)
                begin
                    foreach (frame_m[i]) frame_m[i] = '0;
                end
                else
                begin
                    sp_m = sp_m - 4'd1;
                    nxt = stack_m[sp_m];
                end
            end
            4'h1: nxt = op[11:0];
            4'h2:
            begin
                stack_m[sp_m] = nxt;
                sp_m = sp_m + 4'd1;
                nxt = op[11:0];
            end
            4'h3: if (a == nn) nxt += 12'd2;
            4'h4: if (a != nn) nxt += 12'd2;
            4'h5: if (a == b) nxt += 12'd2;
            4'h6: vreg_m[x] = nn;
            4'h7: vreg_m[x] = a + nn;
            4'h8:
            begin
                case (n)
                    4'h0: vreg_m[x] = b;
                    4'h1: vreg_m[x] = a | b;
                    4'h2: vreg_m[x] = a & b;
                    4'h3: vreg_m[x] = a ^ b;
                    4'h4:
                    begin
                        sum = a + b;
                        vreg_m[x] = sum[7:0];
                        vreg_m[15] = {7'd0, sum[8]};
                    end
                    4'h5:
                    begin
                        f = (a >= b);
                        vreg_m[x] = a - b;
                        vreg_m[15] = f;
                    end
                    4'h6:
                    begin
                        vreg_m[x] = a >> 1;
                        vreg_m[15] = {7'd0, a[0]};
                    end
                    4'h7:
                    begin
                        f = (b >= a);
                        vreg_m[x] = b - a;
                        vreg_m[15] = f;
                    end
                    4'hE:
                    begin
                        vreg_m[x] = a << 1;
                        vreg_m[15] = {7'd0, a[7]};
                    end
                    default: ;
                endcase
            end
            4'h9: if (a != b) nxt += 12'd2;
            4'hA: idx_m = {4'd0, op[11:0]};
            4'hD:
            begin
                hit = 1'b0;
                for (int r = 0; r < n; r++)
                begin
                    bits = mem_m[12'(idx_m + r)];
                    yy = (b + r) % SCREEN_HEIGHT;
                    for (int c = 0; c < 8; c++)
                    begin
                        if (bits[7 - c])
                        begin
                            xx = (a + c) % SCREEN_WIDTH;
                            m = 64'd1 << (63 - xx);
                            if (frame_m[yy] & m) hit = 1'b1;
                            frame_m[yy] ^= m;
                        end
                    end
                end
                vreg_m[15] = {7'd0, hit};
            end
            4'hE:
            begin
                if (nn == 8'h9E && keys[a[3:0]]) nxt += 12'd2;
                if (nn == 8'hA1 && !keys[a[3:0]]) nxt += 12'd2;
            end
            4'hF:
            begin
                case (nn)
                    8'h07: vreg_m[x] = dt_m;
                    8'h15: dt_m = a;
                    8'h1E: idx_m = idx_m + a;
                    8'h29: idx_m = 16'(5 * a);
                    8'h33:
                    begin
                        mem_m[idx_m[11:0]] = a / 100;
                        mem_m[12'(idx_m + 1)] = (a % 100) / 10;
                        mem_m[12'(idx_m + 2)] = a % 10;
                    end
                    8'h55: for (int k = 0; k <= x; k++) mem_m[12'(idx_m + k)] = vreg_m[k];
                    8'h65: for (int k = 0; k <= x; k++) vreg_m[k] = mem_m[12'(idx_m + k)];
                    default: ;
                endcase
            end
            default: ;
        endcase
        pc_m = nxt;
        return ST_DONE;
    endfunction

    function automatic svic_result_t predict_result(input svic_item_t it);
        svic_result_t r;
        r = '0;
        case (it.action)
            ACT_LOAD: mem_m[it.address] = it.data;
            ACT_STEP: r.status = run_m ? interpret_step(it.keys) : ST_HALTED;
            ACT_ROW:  r.display_row = frame_m[it.address[4:0]];
            default:  r.read_byte = mem_m[it.address];
        endcase
        r.program_counter = pc_m;
        r.index_value = idx_m;
        r.delay_value = dt_m;
        r.sound_value = st_m;
        return r;
    endfunction

    // drives one request and queues its expected result; valid stays up after the
    // accepting edge until the next request replaces it or the sender idles
    task automatic send_request(input svic_item_t it);
        svic_result_t r;
        while ($urandom_range(99) < idle_send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_item <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        r = predict_result(it);
        pending_results.push_back(r);
    endtask

    task automatic send_fields(input logic [1:0] act, input int adr, input int dat,
                               input int keys);
        svic_item_t it;
        it.action = act; it.address = adr[11:0]; it.data = dat[7:0]; it.keys = keys[15:0];
        send_request(it);
    endtask

    task automatic load_opcode(input int adr, input logic [15:0] op);
        send_fields(ACT_LOAD, adr, op[15:8], 0);
        send_fields(ACT_LOAD, adr + 1, op[7:0], 0);
    endtask

    task automatic wait_drained;
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_run_enable(input logic val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_RUN_ENABLE; pwdata <= {31'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        run_m = val;
    endtask

    // result checker with random receiver stalls
    always @(posedge clk)
    begin
        svic_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("unexpected result %h", out_result);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_result.status !== want.status)
                    report_mismatch("status", out_result.status, want.status);
                if (out_result.program_counter !== want.program_counter)
                    report_mismatch("pc", out_result.program_counter, want.program_counter);
                if (out_result.index_value !== want.index_value)
                    report_mismatch("index", out_result.index_value, want.index_value);
                if (out_result.delay_value !== want.delay_value)
                    report_mismatch("delay", out_result.delay_value, want.delay_value);
                if (out_result.sound_value !== want.sound_value)
                    report_mismatch("sound", out_result.sound_value, want.sound_value);
                if (out_result.read_byte !== want.read_byte)
                    report_mismatch("read_byte", out_result.read_byte, want.read_byte);
                if (out_result.display_row !== want.display_row)
                    report_mismatch("row", out_result.display_row, want.display_row);
            end
        end
        out_stall <= ($urandom_range(99) < idle_recv_pct);
    end

    // watchdog on cycles without any accepted request or result
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (pending_results.size() != 0 || in_valid)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // directed table: action, address, data, keys, pinned status
    typedef struct {
        logic [1:0]  act;
        logic [11:0] adr;
        logic [7:0]  dat;
        logic [15:0] keys;
        logic [1:0]  status;
    } row_t;

    row_t directed_rows[] = '{
        '{ACT_READ, 12'hFFF, 8'h00, 16'h0000, ST_DONE},
        '{ACT_ROW,  12'h01F, 8'h00, 16'h0000, ST_DONE},
        '{ACT_STEP, 12'h000, 8'h00, 16'hFFFF, ST_HALTED},   // run disabled
        '{ACT_LOAD, 12'hFFF, 8'hFF, 16'h0000, ST_DONE},
        '{ACT_READ, 12'hFFF, 8'h00, 16'h0000, ST_DONE},
        '{ACT_LOAD, 12'h000, 8'hA5, 16'h0000, ST_DONE},
        '{ACT_READ, 12'h000, 8'h00, 16'h0000, ST_DONE}
    };

    // handcrafted program exercising every opcode class but 7xnn and the wrap cases
    logic [15:0] demo_prog[] = '{
        16'h6AFF, 16'h6B01, 16'h8AB4, 16'h8AB5, 16'h8AB7, 16'h8AB6, 16'h8ABE,
        16'h6FF0, 16'h8F04, 16'hA000, 16'hF033, 16'h60C8, 16'hF015, 16'hF107,
        16'hF01E, 16'hF129, 16'hAFFE, 16'hF355, 16'hF365, 16'h00E0, 16'h6038,
        16'h611E, 16'hA200, 16'hD01F, 16'hD01F, 16'hD010, 16'hE09E, 16'hE0A1,
        16'h3038, 16'h4038, 16'h5010, 16'h9010, 16'h8019, 16'hF0FF, 16'h0123,
        16'hB000, 16'hC000, 16'hF00A, 16'hF018, 16'h2260, 16'h00EE, 16'h1FFE
    };

    function automatic logic [15:0] random_opcode;
        logic [15:0] op;
        logic [3:0]  sub [9] = '{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE};
        logic [7:0]  fnn [9] = '{8'h07, 8'h15, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65, 8'h0A, 8'h18};
        op = 16'($urandom);
        case ($urandom_range(9))
            0: op[15:12] = 4'h8;
            1: begin op[15:12] = 4'h8; op[3:0] = sub[$urandom_range(8)]; end
            2: begin op[15:12] = 4'hF; op[7:0] = fnn[$urandom_range(8)]; end
            3: begin op[15:12] = 4'hE; op[7:0] = $urandom_range(1) ? 8'h9E : 8'hA1; end
            4: op[15:12] = 4'hD;
            5: op[15:12] = 4'($urandom_range(3, 7));
            6: op = $urandom_range(1) ? 16'h00E0 : 16'h00EE;
            7: op[15:12] = 4'hA;
            default: ;
        endcase
        return op;
    endfunction

    initial
    begin
        svic_result_t pin;
        int base;
        foreach (mem_m[i]) mem_m[i] = '0;
        foreach (vreg_m[i]) vreg_m[i] = '0;
        foreach (stack_m[i]) stack_m[i] = '0;
        foreach (frame_m[i]) frame_m[i] = '0;
        sp_m = '0; pc_m = START_ADDRESS_DEFAULT; idx_m = '0; dt_m = '0; st_m = '0;
        run_m = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, pinned status checked against the model at a glance
        foreach (directed_rows[i])
        begin
            send_fields(directed_rows[i].act, directed_rows[i].adr,
                        directed_rows[i].dat, directed_rows[i].keys);
            pin = pending_results[$];
            if (pin.status !== directed_rows[i].status)
                report_mismatch("table status", pin.status, directed_rows[i].status);
        end
        foreach (demo_prog[i]) load_opcode(12'h200 + 2 * i, demo_prog[i]);
        load_opcode(12'h260, 16'h00EE);
        wait_drained;
        write_run_enable(1'b1);
        foreach (demo_prog[i]) send_fields(ACT_STEP, 0, 0, 16'($urandom));
        for (int r = 0; r < 32; r += 7) send_fields(ACT_ROW, r, 0, 0);

        // random phases: mostly receive-side idle, mostly send-side idle, none
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_send_pct = (phase == 0) ? 25 : (phase == 1) ? 64 : 0;
            idle_recv_pct = (phase == 0) ? 64 : (phase == 1) ? 25 : 0;
            for (int prog = 0; prog < 13; prog++)
            begin
                // write a short random program at a random spot, then step from the current pc
                base = $urandom_range(4095);
                for (int k = 0; k < 10; k++)
                    load_opcode((base + 2 * k) % 4096, random_opcode());
                for (int k = 0; k < 4; k++)
                    send_fields($urandom_range(1) ? ACT_LOAD : ACT_READ,
                                $urandom_range(4095), $urandom_range(255), 0);
                for (int k = 0; k < 14; k++)
                    send_fields(ACT_STEP, $urandom_range(4095), $urandom_range(255),
                                16'($urandom));
                send_fields(ACT_ROW, $urandom_range(4095), 0, 0);
                if (prog == 5) wait_drained;   // sender holds off until all results are in
            end
            wait_drained;
            write_run_enable(phase == 1 ? 1'b0 : 1'b1);
            send_fields(ACT_STEP, 0, 0, 16'hFFFF);
            wait_drained;
            write_run_enable(1'b1);
        end

        wait_drained;
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### files.f
hdl/svic_pkg.sv
hdl/svic_ram.sv
hdl/svic_dp.sv
hdl/svic_ctrl.sv
hdl/sprite_vm_instruction_core.sv
test/tb_sprite_vm_instruction_core.sv
